FILE: sv/assert_macros.svh
// Assertion helpers shared by the matching block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define BMM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define BMM_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bmm_pkg.sv
// ----------------------------------------------------------------------------
// Matching package
// Shared sizes, codes, types and mask helpers of the matching block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmm_pkg;

   localparam int MAX_LEFT  = 32;
   localparam int MAX_RIGHT = 32;
   localparam int ROW_W     = 32;
   localparam int IDX_W     = 5;
   localparam int CNT_W     = 6;

   localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
   localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
   localparam logic [1:0] OP_RUN        = 2'd2;
   localparam logic [1:0] OP_RESERVED   = 2'd3;

   localparam logic CSR_LEFT_COUNT  = 1'b0;
   localparam logic CSR_RIGHT_COUNT = 1'b1;

   typedef struct packed {
      logic             left_en;
      logic [IDX_W-1:0] left_addr;
      logic             right_en;
      logic [IDX_W-1:0] right_addr;
   } bmm_rd_type;

   function automatic logic [ROW_W-1:0] bmm_ge_mask(input logic [CNT_W-1:0] n);
      logic [ROW_W:0] t;
      t = {(ROW_W+1){1'b1}} << n;
      return t[ROW_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] bmm_lowest(input logic [ROW_W-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (v[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] bmm_clamp(input logic [CNT_W-1:0] n,
                                                  input logic [CNT_W-1:0] lim);
      return (n > lim) ? lim : n;
   endfunction

endpackage

FILE: sv/bmm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bmm_search.sv
// ----------------------------------------------------------------------------
// Augmenting path search
// Sequencer with an explicit stack that runs the matching over the row memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmm_search import bmm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] left_count,
   input  logic [CNT_W-1:0] right_count,
   input  logic [ROW_W-1:0] left_data,
   input  logic [ROW_W-1:0] right_data,
   output bmm_rd_type       rd,
   output logic             idle,
   output logic             done,
   output logic [CNT_W-1:0] total
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROOT   = 3'd1;
   localparam logic [2:0] ST_LREAD  = 3'd2;
   localparam logic [2:0] ST_LWAIT  = 3'd3;
   localparam logic [2:0] ST_PICK   = 3'd4;
   localparam logic [2:0] ST_CHECK  = 3'd5;
   localparam logic [2:0] ST_COMMIT = 3'd6;

   logic [2:0]       state_ff;
   logic [CNT_W-1:0] depth_ff;
   logic [CNT_W-1:0] root_ff;
   logic [CNT_W-1:0] total_ff;
   logic [IDX_W-1:0] d_ff;
   logic [IDX_W-1:0] r_ff;
   logic [ROW_W-1:0] lrow_ff;
   logic [ROW_W-1:0] visited_ff;
   logic [MAX_RIGHT-1:0] pval_ff;
   logic [IDX_W-1:0] partner_ff [MAX_RIGHT];
   logic [IDX_W-1:0] stk_left_ff [MAX_RIGHT];
   logic [CNT_W-1:0] stk_next_ff [MAX_RIGHT];
   logic [IDX_W-1:0] stk_via_ff [MAX_RIGHT];

   logic [CNT_W-1:0] lc;
   logic [CNT_W-1:0] rc;
   logic [IDX_W-1:0] top;
   logic [IDX_W-1:0] sa;
   logic [ROW_W-1:0] cand;
   logic [IDX_W-1:0] pick;

   assign lc   = bmm_clamp(left_count, CNT_W'(MAX_LEFT));
   assign rc   = bmm_clamp(right_count, CNT_W'(MAX_RIGHT));
   assign top  = IDX_W'(depth_ff - CNT_W'(1));
   assign sa   = (state_ff == ST_COMMIT) ? d_ff : top;
   assign cand = lrow_ff & ~visited_ff & bmm_ge_mask(stk_next_ff[sa]) & ~bmm_ge_mask(rc);
   assign pick = bmm_lowest(cand);

   always_comb begin
      rd.left_en    = (state_ff == ST_LREAD);
      rd.left_addr  = stk_left_ff[sa];
      rd.right_en   = (state_ff == ST_PICK) && (cand != '0);
      rd.right_addr = pick;
   end

   assign idle  = (state_ff == ST_IDLE);
   assign done  = (state_ff == ST_ROOT) && (root_ff >= lc);
   assign total = total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         depth_ff   <= '0;
         root_ff    <= '0;
         total_ff   <= '0;
         d_ff       <= '0;
         visited_ff <= '0;
         pval_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  pval_ff  <= '0;
                  total_ff <= '0;
                  root_ff  <= '0;
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (root_ff >= lc) begin
                  state_ff <= ST_IDLE;
               end else begin
                  visited_ff     <= '0;
                  stk_left_ff[0] <= IDX_W'(root_ff);
                  stk_next_ff[0] <= '0;
                  depth_ff       <= CNT_W'(1);
                  state_ff       <= ST_LREAD;
               end
            end
            ST_LREAD: begin
               state_ff <= ST_LWAIT;
            end
            ST_LWAIT: begin
               lrow_ff  <= left_data;
               state_ff <= ST_PICK;
            end
            ST_PICK: begin
               if (cand == '0) begin
                  depth_ff <= depth_ff - CNT_W'(1);
                  if (depth_ff == CNT_W'(1)) begin
                     root_ff  <= root_ff + CNT_W'(1);
                     state_ff <= ST_ROOT;
                  end else begin
                     state_ff <= ST_LREAD;
                  end
               end else begin
                  r_ff     <= pick;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               stk_next_ff[top] <= CNT_W'(r_ff) + CNT_W'(1);
               if (right_data[stk_left_ff[top]]) begin
                  visited_ff[r_ff] <= 1'b1;
                  stk_via_ff[top]  <= r_ff;
                  if (!pval_ff[r_ff]) begin
                     d_ff     <= '0;
                     state_ff <= ST_COMMIT;
                  end else begin
                     stk_left_ff[depth_ff[IDX_W-1:0]] <= partner_ff[r_ff];
                     stk_next_ff[depth_ff[IDX_W-1:0]] <= '0;
                     depth_ff <= depth_ff + CNT_W'(1);
                     state_ff <= ST_LREAD;
                  end
               end else begin
                  state_ff <= ST_PICK;
               end
            end
            ST_COMMIT: begin
               pval_ff[stk_via_ff[d_ff]]    <= 1'b1;
               partner_ff[stk_via_ff[d_ff]] <= stk_left_ff[d_ff];
               if (d_ff == top) begin
                  total_ff <= total_ff + CNT_W'(1);
                  root_ff  <= root_ff + CNT_W'(1);
                  state_ff <= ST_ROOT;
               end else begin
                  d_ff <= d_ff + IDX_W'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `BMM_ASSERT(a_depth_bound, depth_ff <= CNT_W'(MAX_RIGHT), "search stack overflow")
   `BMM_ASSERT(a_total_bound, state_ff == ST_IDLE || total_ff <= root_ff, "total exceeds roots")
   `BMM_ASSERT_NEXT(a_start_busy, state_ff == ST_IDLE && start, state_ff == ST_ROOT,
                    "run did not start")

endmodule

FILE: sv/mutual_bipartite_max_matching.sv
// Timing: a row load is written at its accepting edge; a run raises its result after
// the search has taken each root in turn, fetched rows, tried candidates, backed out
// of exhausted levels and committed each edge of every augmenting path.
// Throughput: one load word per cycle while the search is idle and no result is pending;
// one run at a time, set by the search sequencer. Reset: synchronous active high;
// counts return to 32, matching state clears, row memories hold no defined value until loaded.
// ----------------------------------------------------------------------------
// Mutual bipartite maximum matching
// Row memories, configuration and handshake around the augmenting path search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mutual_bipartite_max_matching import bmm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_opcode,
   input  logic [IDX_W-1:0] req_row_index,
   input  logic [ROW_W-1:0] req_row_mask,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CNT_W-1:0] rsp_matched_count,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CNT_W-1:0] csr_wdata
);

   logic [CNT_W-1:0] left_count_ff;
   logic [CNT_W-1:0] right_count_ff;
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             accept;
   logic             start;
   logic             idle;
   logic             done;
   logic [CNT_W-1:0] total;
   logic [ROW_W-1:0] left_data;
   logic [ROW_W-1:0] right_data;
   bmm_rd_type       rd;

   assign req_ready         = idle && !rsp_valid_ff;
   assign accept            = req_valid && req_ready;
   assign start             = accept && (req_opcode == OP_RUN);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_count_ff  <= CNT_W'(MAX_LEFT);
         right_count_ff <= CNT_W'(MAX_RIGHT);
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LEFT_COUNT:  left_count_ff  <= csr_wdata;
               CSR_RIGHT_COUNT: right_count_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
            rsp_count_ff <= total;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   bmm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_LEFT)) u_left_rows (
      .clock   (clock),
      .wr_en   (accept && (req_opcode == OP_LOAD_LEFT)),
      .wr_addr (req_row_index),
      .wr_data (req_row_mask),
      .rd_en   (rd.left_en),
      .rd_addr (rd.left_addr),
      .rd_data (left_data)
   );

   bmm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_RIGHT)) u_right_rows (
      .clock   (clock),
      .wr_en   (accept && (req_opcode == OP_LOAD_RIGHT)),
      .wr_addr (req_row_index),
      .wr_data (req_row_mask),
      .rd_en   (rd.right_en),
      .rd_addr (rd.right_addr),
      .rd_data (right_data)
   );

   bmm_search u_search (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .left_count  (left_count_ff),
      .right_count (right_count_ff),
      .left_data   (left_data),
      .right_data  (right_data),
      .rd          (rd),
      .idle        (idle),
      .done        (done),
      .total       (total)
   );

   `BMM_ASSERT(a_done_free, !(done && rsp_valid_ff), "result produced while one is pending")
   `BMM_ASSERT_NEXT(a_run_busy, start, !req_ready, "ready high during a run")

endmodule

FILE: tb/mutual_bipartite_max_matching_tb.sv
// ----------------------------------------------------------------------------
// Mutual bipartite maximum matching testbench
// Loads preference rows through the request channel, issues run commands and
// compares every returned matching size with a cycle-free predictor that
// repeats the augmenting path search, under several vertex count settings
// and random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mutual_bipartite_max_matching_tb;
   import bmm_pkg::*;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [IDX_W-1:0] row_index;
      logic [ROW_W-1:0] row_mask;
   } req_word_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [1:0]       req_opcode;
   logic [IDX_W-1:0] req_row_index;
   logic [ROW_W-1:0] req_row_mask;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [CNT_W-1:0] rsp_matched_count;
   logic             csr_we;
   logic             csr_index;
   logic [CNT_W-1:0] csr_wdata;

   mutual_bipartite_max_matching DUT (.*);

   req_word_type     pending_words[$];
   logic [CNT_W-1:0] expected_sizes[$];
   logic [ROW_W-1:0] pred_left_rows[MAX_LEFT];
   logic [ROW_W-1:0] pred_right_rows[MAX_RIGHT];
   int               pred_left_count;
   int               pred_right_count;
   int               sender_idle_pct;
   int               receiver_idle_pct;
   int               hold_cycles;
   int               mismatches;
   int               stall_cycles;

   localparam int STALL_LIMIT = 400000;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit mutual_edge(int u, int r);
      return pred_left_rows[u][r] && pred_right_rows[r][u];
   endfunction

   // Kuhn search with left vertices in order and right vertices scanned upward.
   function automatic int predict_matching_size();
      int  partner[MAX_RIGHT];
      bit  visited[MAX_RIGHT];
      int  stack_left[MAX_RIGHT + 1];
      int  stack_next[MAX_RIGHT + 1];
      int  stack_via[MAX_RIGHT + 1];
      int  lc;
      int  rc;
      int  total;
      int  depth;
      int  top;
      int  r;
      bit  found;
      lc = (pred_left_count > MAX_LEFT) ? MAX_LEFT : pred_left_count;
      rc = (pred_right_count > MAX_RIGHT) ? MAX_RIGHT : pred_right_count;
      total = 0;
      for (int i = 0; i < MAX_RIGHT; i++) partner[i] = -1;
      for (int u = 0; u < lc; u++) begin
         for (int i = 0; i < MAX_RIGHT; i++) visited[i] = 1'b0;
         depth = 1;
         stack_left[0] = u;
         stack_next[0] = 0;
         found = 1'b0;
         while (depth > 0 && !found) begin
            top = depth - 1;
            r = stack_next[top];
            while (r < rc && !(mutual_edge(stack_left[top], r) && !visited[r])) r++;
            if (r >= rc) begin
               stack_next[top] = rc;
               depth--;
            end else begin
               visited[r] = 1'b1;
               stack_next[top] = r + 1;
               stack_via[top] = r;
               if (partner[r] < 0) begin
                  for (int d = 0; d <= top; d++) partner[stack_via[d]] = stack_left[d];
                  found = 1'b1;
               end else begin
                  stack_left[depth] = partner[r];
                  stack_next[depth] = 0;
                  depth++;
               end
            end
         end
         if (found) total++;
      end
      return total;
   endfunction

   function automatic void predict_word(req_word_type w);
      case (w.opcode)
         OP_LOAD_LEFT: begin
            pred_left_rows[w.row_index] = w.row_mask;
         end
         OP_LOAD_RIGHT: begin
            pred_right_rows[w.row_index] = w.row_mask;
         end
         OP_RUN: begin
            expected_sizes.push_back(CNT_W'(predict_matching_size()));
         end
         default: begin
         end
      endcase
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid     <= 1'b1;
            req_opcode    <= pending_words[0].opcode;
            req_row_index <= pending_words[0].row_index;
            req_row_mask  <= pending_words[0].row_mask;
            void'(pending_words.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         predict_word({req_opcode, req_row_index, req_row_mask});
   end

   // Receiver readiness and monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sizes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: size %0d", rsp_matched_count);
         end else begin
            if (rsp_matched_count !== expected_sizes[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("size mismatch: expected %0d, actual %0d",
                           expected_sizes[0], rsp_matched_count);
            end
            void'(expected_sizes.pop_front());
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || pending_words.size() == 0 && expected_sizes.size() == 0) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles > STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic void queue_word(logic [1:0] op, int idx, logic [ROW_W-1:0] mask);
      pending_words.push_back({op, IDX_W'(idx), mask});
   endfunction

   function automatic logic [ROW_W-1:0] random_row(int density);
      logic [ROW_W-1:0] m;
      for (int k = 0; k < ROW_W; k++) m[k] = ($urandom_range(99) < density);
      return m;
   endfunction

   // Queues a full graph over all 32 rows of each side plus a run.
   function automatic void queue_graph(int density);
      for (int i = 0; i < MAX_LEFT; i++) queue_word(OP_LOAD_LEFT, i, random_row(density));
      for (int i = 0; i < MAX_RIGHT; i++) queue_word(OP_LOAD_RIGHT, i, random_row(density));
      queue_word(OP_RUN, $urandom_range(31), $urandom);
   endfunction

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_sizes.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_counts(int lc, int rc);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_LEFT_COUNT;
      csr_wdata <= CNT_W'(lc);
      @(posedge clock);
      csr_index <= CSR_RIGHT_COUNT;
      csr_wdata <= CNT_W'(rc);
      @(posedge clock);
      csr_we <= 1'b0;
      pred_left_count  = lc;
      pred_right_count = rc;
   endtask

   initial begin
      int lc_pick[8] = '{32, 1, 63, 0, 17, 32, 5, 40};
      int rc_pick[8] = '{32, 1, 0, 63, 32, 9, 32, 33};
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_LOAD_LEFT;
      req_row_index = '0;
      req_row_mask = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_LEFT_COUNT;
      csr_wdata = '0;
      sender_idle_pct = 34;
      receiver_idle_pct = 88;
      hold_cycles = 0;
      mismatches = 0;
      stall_cycles = 0;
      pred_left_count = 32;
      pred_right_count = 32;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes, all opcodes, ignored code, reset counts.
      for (int i = 0; i < MAX_LEFT; i++) queue_word(OP_LOAD_LEFT, i, '1);
      for (int i = 0; i < MAX_RIGHT; i++) queue_word(OP_LOAD_RIGHT, i, '1);
      queue_word(OP_RUN, 31, '1);
      queue_word(OP_RESERVED, 5, 32'h0);
      queue_word(OP_LOAD_LEFT, 0, 32'h0);
      queue_word(OP_RUN, 0, 32'h0);
      queue_word(OP_LOAD_RIGHT, 31, 32'h0);
      queue_word(OP_RESERVED, 31, '1);
      queue_word(OP_RUN, 0, '1);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 3) begin
            sender_idle_pct = 88;
            receiver_idle_pct = 34;
         end else if (phase == 6) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         write_counts(lc_pick[phase], rc_pick[phase]);
         if (phase == 2) hold_cycles = 600;
         for (int g = 0; g < 2; g++) begin
            if (g == 0) queue_graph($urandom_range(5, 95));
            for (int k = 0; k < 8; k++) begin
               if ($urandom_range(3) == 0)
                  queue_word(OP_RESERVED, $urandom_range(31), $urandom);
               else
                  queue_word(($urandom_range(1) == 0) ? OP_LOAD_LEFT : OP_LOAD_RIGHT,
                             $urandom_range(31), random_row($urandom_range(10, 90)));
               if ($urandom_range(2) == 0) queue_word(OP_RUN, $urandom_range(31), $urandom);
            end
            queue_word(OP_RUN, $urandom_range(31), $urandom);
            if (g == 0 && phase == 4) wait_drained();
         end
         wait_drained();
      end
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/bmm_pkg.sv
sv/bmm_ram.sv
sv/bmm_search.sv
sv/mutual_bipartite_max_matching.sv
tb/mutual_bipartite_max_matching_tb.sv
